FILE: rtl/b24d_pkg.sv
// Package for the 24-bit BMP stream decoder: item and result records,
// phase and code enums, header byte offsets and the end-of-stream error map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b24d_pkg;

  localparam logic [7:0] MAGIC_FIRST  = 8'h42;
  localparam logic [7:0] MAGIC_SECOND = 8'h4D;
  localparam logic [7:0] ALPHA_BYTE   = 8'hFF;

  localparam logic [5:0] OFS_WIDTH  = 6'd18;
  localparam logic [5:0] OFS_HEIGHT = 6'd22;
  localparam logic [5:0] OFS_TAIL   = 6'd26;
  localparam logic [5:0] OFS_PIXELS = 6'd54;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_SKIP   = 3'd1,
    PH_WIDTH  = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_TAIL   = 3'd4,
    PH_PIXEL  = 3'd5,
    PH_PAD    = 3'd6,
    PH_IDLE   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_BAD_MAGIC     = 4'd0,
    ERR_SKIP_MISSING  = 4'd1,
    ERR_WIDTH_MISSING = 4'd2,
    ERR_WIDTH_LARGE   = 4'd3,
    ERR_HEIGHT_MISS   = 4'd4,
    ERR_HEIGHT_LARGE  = 4'd5,
    ERR_TAIL_MISSING  = 4'd6,
    ERR_COLOR_MISSING = 4'd7,
    ERR_PAD_MISSING   = 4'd8
  } err_t;

  // classified input item
  typedef struct packed {
    logic       eos;
    logic       second_magic;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [12:0] width;
    logic [12:0] height;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] color;
    err_t        err;
    logic        done;
  } result_t;

  function automatic err_t eos_error(input phase_t ph);
    err_t e;
    unique case (ph)
      PH_MAGIC:  e = ERR_BAD_MAGIC;
      PH_SKIP:   e = ERR_SKIP_MISSING;
      PH_WIDTH:  e = ERR_WIDTH_MISSING;
      PH_HEIGHT: e = ERR_HEIGHT_MISS;
      PH_TAIL:   e = ERR_TAIL_MISSING;
      PH_PIXEL:  e = ERR_COLOR_MISSING;
      PH_PAD:    e = ERR_PAD_MISSING;
      default:   e = ERR_BAD_MAGIC;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/b24d_front.sv
// Front stage: registers each input item and tags it for the parser.
// Depends on b24d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b24d_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire logic [7:0]     data_byte,
  input  wire logic           end_of_stream,
  output logic                q_push,
  input  wire logic           q_full,
  output b24d_pkg::item_t     q_item
);

  logic            held_valid;
  b24d_pkg::item_t held;
  logic            take;

  assign full   = held_valid && q_full;
  assign take   = push && !full;
  assign q_push = held_valid && !q_full;
  assign q_item = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (q_push) begin
      held_valid <= 1'b0;
    end
  end

  // tag and hold
  always_ff @(posedge clk) begin
    if (take) begin
      held.eos          <= end_of_stream;
      held.second_magic <= (data_byte == b24d_pkg::MAGIC_SECOND);
      held.data         <= data_byte;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b24d_queue.sv
// Two-entry queue of tagged items between the front stage and the parser.
// Depends on b24d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b24d_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr,
  input  wire b24d_pkg::item_t din,
  output logic            full,
  input  wire logic       rd,
  output logic            empty,
  output b24d_pkg::item_t dout
);

  b24d_pkg::item_t mem [2];
  logic            wp;
  logic            rp;
  logic [1:0]      cnt;
  logic [1:0]      cnt_next;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rp];

  always_comb begin
    cnt_next = cnt;
    if (wr && !full)
      cnt_next = cnt_next + 2'd1;
    if (rd && !empty)
      cnt_next = cnt_next - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (wr && !full)
        wp <= ~wp;
      if (rd && !empty)
        rp <= ~rp;
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full)
      mem[wp] <= din;
  end

endmodule

`default_nettype wire

FILE: rtl/b24d_back.sv
// Back stage: header and pixel parser with a two-entry result queue.
// Depends on b24d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b24d_back #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire b24d_pkg::item_t it,
  output logic                 q_pop,
  output logic                 empty,
  input  wire logic            pop,
  output b24d_pkg::result_t    head
);

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int CW    = DIM_W + 1;

  b24d_pkg::phase_t phase;
  b24d_pkg::phase_t phase_next;
  logic [5:0]       header_offset;
  logic [5:0]       header_offset_next;
  logic [31:0]      word_assembly;
  logic [31:0]      word_assembly_next;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] width_reg_next;
  logic [DIM_W-1:0] height_reg;
  logic [DIM_W-1:0] height_reg_next;
  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] column_count_next;
  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] row_count_next;
  logic [1:0]       pixel_byte_index;
  logic [1:0]       pixel_byte_index_next;
  logic [15:0]      held_bytes;
  logic [15:0]      held_bytes_next;
  logic [1:0]       padding_left;
  logic [1:0]       padding_left_next;

  b24d_pkg::result_t res;
  logic              res_valid;

  logic [5:0]  off_inc;
  logic [1:0]  byte_sel;
  logic [31:0] word_new;
  logic        word_big;
  logic        magic_ok;
  logic        dims_zero;
  logic        col_last;
  logic        row_last;
  logic [1:0]  pad_dec;

  // result queue
  b24d_pkg::result_t omem [2];
  logic              owp;
  logic              orp;
  logic [1:0]        ocnt;
  logic [1:0]        ocnt_next;
  logic              opop;

  assign q_pop = !q_empty && (ocnt != 2'd2);

  assign off_inc   = header_offset + 6'd1;
  assign byte_sel  = header_offset[1:0] - 2'd2;
  assign word_new  = word_assembly | (32'(it.data) << {byte_sel, 3'b000});
  assign word_big  = word_new > 32'(MAX_DIMENSION);
  assign magic_ok  = (word_assembly == 32'(b24d_pkg::MAGIC_FIRST)) && it.second_magic;
  assign dims_zero = (width_reg == '0) || (height_reg == '0);
  assign col_last  = (CW'(column_count) + CW'(1)) >= CW'(width_reg);
  assign row_last  = (CW'(row_count) + CW'(1)) >= CW'(height_reg);
  assign pad_dec   = padding_left - 2'd1;

  always_comb begin
    phase_next = phase;
    if (q_pop) begin
      if (it.eos) begin
        phase_next = b24d_pkg::PH_MAGIC;
      end else begin
        unique case (phase)
          b24d_pkg::PH_MAGIC: begin
            if (header_offset != 6'd0)
              phase_next = magic_ok ? b24d_pkg::PH_SKIP : b24d_pkg::PH_IDLE;
          end
          b24d_pkg::PH_SKIP: begin
            if (off_inc >= b24d_pkg::OFS_WIDTH)
              phase_next = b24d_pkg::PH_WIDTH;
          end
          b24d_pkg::PH_WIDTH: begin
            if (off_inc >= b24d_pkg::OFS_HEIGHT)
              phase_next = word_big ? b24d_pkg::PH_IDLE : b24d_pkg::PH_HEIGHT;
          end
          b24d_pkg::PH_HEIGHT: begin
            if (off_inc >= b24d_pkg::OFS_TAIL)
              phase_next = word_big ? b24d_pkg::PH_IDLE : b24d_pkg::PH_TAIL;
          end
          b24d_pkg::PH_TAIL: begin
            if (off_inc >= b24d_pkg::OFS_PIXELS)
              phase_next = dims_zero ? b24d_pkg::PH_IDLE : b24d_pkg::PH_PIXEL;
          end
          b24d_pkg::PH_PIXEL: begin
            if (pixel_byte_index == 2'd2 && col_last) begin
              if (width_reg[1:0] != 2'd0)
                phase_next = b24d_pkg::PH_PAD;
              else if (row_last)
                phase_next = b24d_pkg::PH_IDLE;
            end
          end
          b24d_pkg::PH_PAD: begin
            if (pad_dec == 2'd0)
              phase_next = (CW'(row_count) >= CW'(height_reg)) ?
                           b24d_pkg::PH_IDLE : b24d_pkg::PH_PIXEL;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  always_comb begin
    header_offset_next    = header_offset;
    word_assembly_next    = word_assembly;
    width_reg_next        = width_reg;
    height_reg_next       = height_reg;
    column_count_next     = column_count;
    row_count_next        = row_count;
    pixel_byte_index_next = pixel_byte_index;
    held_bytes_next       = held_bytes;
    padding_left_next     = padding_left;
    res_valid             = 1'b0;
    res                   = '0;
    if (q_pop) begin
      if (it.eos) begin
        // rearm for the next file
        header_offset_next    = '0;
        word_assembly_next    = '0;
        width_reg_next        = '0;
        height_reg_next       = '0;
        column_count_next     = '0;
        row_count_next        = '0;
        pixel_byte_index_next = '0;
        held_bytes_next       = '0;
        padding_left_next     = '0;
        res_valid             = (phase != b24d_pkg::PH_IDLE);
        res.kind              = b24d_pkg::KIND_ERROR;
        res.err               = b24d_pkg::eos_error(phase);
      end else begin
        unique case (phase)
          b24d_pkg::PH_MAGIC: begin
            if (header_offset == 6'd0) begin
              word_assembly_next = 32'(it.data);
              header_offset_next = 6'd1;
            end else begin
              header_offset_next = 6'd2;
              if (!magic_ok) begin
                res_valid = 1'b1;
                res.kind  = b24d_pkg::KIND_ERROR;
                res.err   = b24d_pkg::ERR_BAD_MAGIC;
              end
            end
          end
          b24d_pkg::PH_SKIP: begin
            header_offset_next = off_inc;
            if (off_inc >= b24d_pkg::OFS_WIDTH)
              word_assembly_next = '0;
          end
          b24d_pkg::PH_WIDTH: begin
            header_offset_next = off_inc;
            word_assembly_next = word_new;
            if (off_inc >= b24d_pkg::OFS_HEIGHT) begin
              if (word_big) begin
                res_valid = 1'b1;
                res.kind  = b24d_pkg::KIND_ERROR;
                res.err   = b24d_pkg::ERR_WIDTH_LARGE;
              end else begin
                width_reg_next     = DIM_W'(word_new);
                word_assembly_next = '0;
              end
            end
          end
          b24d_pkg::PH_HEIGHT: begin
            header_offset_next = off_inc;
            word_assembly_next = word_new;
            if (off_inc >= b24d_pkg::OFS_TAIL) begin
              if (word_big) begin
                res_valid = 1'b1;
                res.kind  = b24d_pkg::KIND_ERROR;
                res.err   = b24d_pkg::ERR_HEIGHT_LARGE;
              end else begin
                height_reg_next    = DIM_W'(word_new);
                word_assembly_next = '0;
              end
            end
          end
          b24d_pkg::PH_TAIL: begin
            header_offset_next = off_inc;
            if (off_inc >= b24d_pkg::OFS_PIXELS) begin
              res_valid  = 1'b1;
              res.kind   = b24d_pkg::KIND_HEADER;
              res.width  = 13'(width_reg);
              res.height = 13'(height_reg);
              res.done   = dims_zero;
              if (!dims_zero) begin
                column_count_next     = '0;
                row_count_next        = '0;
                pixel_byte_index_next = '0;
              end
            end
          end
          b24d_pkg::PH_PIXEL: begin
            if (pixel_byte_index == 2'd0) begin
              held_bytes_next       = {8'h00, it.data};
              pixel_byte_index_next = 2'd1;
            end else if (pixel_byte_index == 2'd1) begin
              held_bytes_next[15:8] = it.data;
              pixel_byte_index_next = 2'd2;
            end else begin
              pixel_byte_index_next = 2'd0;
              res_valid  = 1'b1;
              res.kind   = b24d_pkg::KIND_PIXEL;
              res.width  = 13'(width_reg);
              res.height = 13'(height_reg);
              res.x      = 12'(column_count);
              res.y      = 12'(row_count);
              res.color  = {it.data, held_bytes[15:8], held_bytes[7:0],
                            b24d_pkg::ALPHA_BYTE};
              if (col_last) begin
                res.done          = row_last;
                column_count_next = '0;
                row_count_next    = row_count + DIM_W'(1);
                if (width_reg[1:0] != 2'd0)
                  padding_left_next = width_reg[1:0];
              end else begin
                column_count_next = column_count + DIM_W'(1);
              end
            end
          end
          b24d_pkg::PH_PAD: begin
            padding_left_next = pad_dec;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= b24d_pkg::PH_MAGIC;
      header_offset    <= '0;
      word_assembly    <= '0;
      width_reg        <= '0;
      height_reg       <= '0;
      column_count     <= '0;
      row_count        <= '0;
      pixel_byte_index <= '0;
      held_bytes       <= '0;
      padding_left     <= '0;
    end else begin
      phase            <= phase_next;
      header_offset    <= header_offset_next;
      word_assembly    <= word_assembly_next;
      width_reg        <= width_reg_next;
      height_reg       <= height_reg_next;
      column_count     <= column_count_next;
      row_count        <= row_count_next;
      pixel_byte_index <= pixel_byte_index_next;
      held_bytes       <= held_bytes_next;
      padding_left     <= padding_left_next;
    end
  end

  assign opop  = pop && (ocnt != 2'd0);
  assign empty = (ocnt == 2'd0);
  assign head  = omem[orp];

  always_comb begin
    ocnt_next = ocnt;
    if (res_valid)
      ocnt_next = ocnt_next + 2'd1;
    if (opop)
      ocnt_next = ocnt_next - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt_next;
      if (res_valid)
        owp <= ~owp;
      if (opop)
        orp <= ~orp;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid)
      omem[owp] <= res;
  end

endmodule

`default_nettype wire

FILE: rtl/bmp_24bit_stream_decoder.sv
// Top level of the 24-bit BMP stream decoder: front stage, item queue, parser.
// Depends on b24d_pkg, b24d_front, b24d_queue and b24d_back.
//
//   channel  handshake    payload
//   input    push / full  data_byte, end_of_stream
//   result   empty / pop  result_kind, image_width, image_height, pixel_x,
//                         pixel_y, color_code, error_code, image_done
//
// One item per cycle sustained while the result queue has room; each item
// passes the front register and item queue, its result the result queue.
// Synchronous reset clears all queues and returns the parser to the magic phase.
// Each side stalls on its own through a two-entry queue; a full result queue
// halts the parser and backs up into full.
`timescale 1ns / 1ps
`default_nettype none

module bmp_24bit_stream_decoder #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       result_kind,
  output logic [12:0]      image_width,
  output logic [12:0]      image_height,
  output logic [11:0]      pixel_x,
  output logic [11:0]      pixel_y,
  output logic [31:0]      color_code,
  output logic [3:0]       error_code,
  output logic             image_done
);

  logic              q_wr;
  logic              q_full;
  logic              q_rd;
  logic              q_empty;
  b24d_pkg::item_t   q_din;
  b24d_pkg::item_t   q_dout;
  b24d_pkg::result_t head;

  b24d_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .q_push        (q_wr),
    .q_full        (q_full),
    .q_item        (q_din)
  );

  b24d_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .din   (q_din),
    .full  (q_full),
    .rd    (q_rd),
    .empty (q_empty),
    .dout  (q_dout)
  );

  b24d_back #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .it      (q_dout),
    .q_pop   (q_rd),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign result_kind  = head.kind;
  assign image_width  = head.width;
  assign image_height = head.height;
  assign pixel_x      = head.x;
  assign pixel_y      = head.y;
  assign color_code   = head.color;
  assign error_code   = head.err;
  assign image_done   = head.done;

endmodule

`default_nettype wire
